### hw/rtl/uvf_pkg.sv
// ----------------------------------------------------------------------------
// uvf_pkg: shared types and constants of the unique value FIFO
// Operation and status codes, the reset limit and the cell control word.
// ----------------------------------------------------------------------------
package uvf_pkg;

  // Built depth and register reset value.
  localparam int unsigned DefaultDepth      = 128;
  localparam logic [7:0]  MaxEntriesReset   = 8'd100;

  // Operation requested by an input word.
  typedef enum logic {
    OP_PUSH = 1'b0,
    OP_POP  = 1'b1
  } op_e;

  // Status carried by every result word.
  typedef enum logic [1:0] {
    STATUS_DONE      = 2'd0,
    STATUS_FULL      = 2'd1,
    STATUS_DUPLICATE = 2'd2,
    STATUS_EMPTY     = 2'd3
  } status_e;

  // Control broadcast from the sequencer to every cell of the chain.
  typedef struct packed {
    logic               push;
    logic               pop;
    logic signed [31:0] value;
  } uvf_cell_ctrl_t;

endpackage

### hw/rtl/uvf_in_if.sv
// ----------------------------------------------------------------------------
// uvf_in_if: request channel of the unique value FIFO
// Valid/ready channel carrying the operation and the value to push.
// ----------------------------------------------------------------------------
interface uvf_in_if;
  logic               valid;
  logic               ready;
  logic               op;
  logic signed [31:0] value;

  modport source (output valid, output op, output value, input ready);
  modport sink   (input valid, input op, input value, output ready);
endinterface

### hw/rtl/uvf_out_if.sv
// ----------------------------------------------------------------------------
// uvf_out_if: result channel of the unique value FIFO
// Valid/ready channel carrying the status, popped value and queue flags.
// ----------------------------------------------------------------------------
interface uvf_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic signed [31:0] popped_value;
  logic               is_empty;
  logic               is_full;
  logic [7:0]         occupancy;

  modport source (output valid, output status, output popped_value, output is_empty,
                  output is_full, output occupancy, input ready);
  modport sink   (input valid, input status, input popped_value, input is_empty,
                  input is_full, input occupancy, output ready);
endinterface

### hw/rtl/uvf_cell.sv
// ----------------------------------------------------------------------------
// uvf_cell: one storage cell of the FIFO chain
// Holds one entry, compares it against the broadcast value, takes a new
// entry when it is the tail, and takes its right neighbor's entry on a pop.
// ----------------------------------------------------------------------------
module uvf_cell
  import uvf_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  uvf_cell_ctrl_t     ctrl_i,
  input  logic               prev_valid_i,
  input  logic               next_valid_i,
  input  logic signed [31:0] next_value_i,
  output logic               valid_o,
  output logic signed [31:0] value_o,
  output logic               match_o
);

  logic               valid_q, valid_d;
  logic signed [31:0] value_q, value_d;

  // A pop shifts the whole chain toward the head; a push fills the first free cell.
  always_comb begin
    valid_d = valid_q;
    value_d = value_q;
    if (ctrl_i.pop) begin
      valid_d = next_valid_i;
      value_d = next_value_i;
    end else if (ctrl_i.push && !valid_q && prev_valid_i) begin
      valid_d = 1'b1;
      value_d = ctrl_i.value;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Entry data needs no reset: it is only seen while the valid bit is set.
  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  // Duplicate detection is local to each cell.
  assign match_o = valid_q && (value_q == ctrl_i.value);
  assign valid_o = valid_q;
  assign value_o = value_q;

endmodule

### hw/rtl/unique_value_fifo.sv
// ----------------------------------------------------------------------------
// unique_value_fifo: FIFO of signed 32-bit values that refuses duplicates
// A row of DEPTH cells holds the queue with the head in cell zero; every
// cell compares its entry against the incoming value in parallel.
// ----------------------------------------------------------------------------
// Usage:
//   in_i carries one request word (op: push or pop, value). out_o returns
//   exactly one result word per request: status, popped value, empty and
//   full flags and the occupancy after the operation.
//   cfg_we_i / cfg_data_i write the occupancy limit max_entries (reset 100);
//   write it only while no request is in flight.
// Timing:
//   A request is registered on acceptance and resolved in the evaluation step,
//   when the cell compare results are OR-reduced and the chain is updated.
//   The result word is registered. A new request is accepted only once the
//   previous one has been resolved; a full result register stalls evaluation.
// Reset:
//   The queue comes up empty, no result is pending, and the limit is 100.
// Back-pressure:
//   While a result waits on out_o.ready, the next request may still be
//   accepted; it is held in the evaluation step until the result register
//   frees up, and in_i.ready stays low meanwhile.
// ----------------------------------------------------------------------------
module unique_value_fifo
  import uvf_pkg::*;
#(
  parameter int unsigned DEPTH = DefaultDepth
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  uvf_in_if.sink     in_i,
  uvf_out_if.source  out_o,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_data_i
);

  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned XW = (CW > 8) ? CW : 8;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EVAL = 2'b10
  } state_e;

  state_e             state_q, state_d;
  logic [7:0]         max_entries_q;
  logic [CW-1:0]      count_q, count_d;
  logic               op_q;
  logic signed [31:0] value_q;

  logic               out_valid_q;
  logic [1:0]         out_status_q;
  logic signed [31:0] out_popped_q;
  logic               out_empty_q;
  logic               out_full_q;
  logic [7:0]         out_occ_q;

  uvf_cell_ctrl_t     ctrl;
  logic [DEPTH-1:0]   cell_valid;
  logic signed [31:0] cell_value [DEPTH];
  logic [DEPTH-1:0]   cell_match;

  logic               out_free;
  logic               commit;
  logic               is_dup;
  logic               limit_hit;
  status_e            status;
  logic signed [31:0] popped;
  logic [XW-1:0]      count_x, count_d_x, max_x;

  // Configuration register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_entries_q <= MaxEntriesReset;
    end else if (cfg_we_i) begin
      max_entries_q <= cfg_data_i;
    end
  end

  // Chain of storage cells; cell zero is the head.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic               prev_valid;
    logic               next_valid;
    logic signed [31:0] next_value;

    if (i == 0) begin : g_head
      assign prev_valid = 1'b1;
    end else begin : g_body
      assign prev_valid = cell_valid[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign next_valid = 1'b0;
      assign next_value = '0;
    end else begin : g_mid
      assign next_valid = cell_valid[i+1];
      assign next_value = cell_value[i+1];
    end

    uvf_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .prev_valid_i (prev_valid),
      .next_valid_i (next_valid),
      .next_value_i (next_value),
      .valid_o      (cell_valid[i]),
      .value_o      (cell_value[i]),
      .match_o      (cell_match[i])
    );
  end

  // Decision for the request under evaluation.
  assign out_free  = !out_valid_q || out_o.ready;
  assign commit    = (state_q == ST_EVAL) && out_free;
  assign is_dup    = |cell_match;
  assign count_x   = XW'(count_q);
  assign max_x     = XW'(max_entries_q);
  assign limit_hit = (count_q != '0) &&
                     ((count_x >= max_x) || (count_q >= CW'(DEPTH)));

  always_comb begin
    status    = STATUS_DONE;
    popped    = '0;
    count_d   = count_q;
    ctrl.push = 1'b0;
    ctrl.pop  = 1'b0;
    ctrl.value = value_q;
    if (op_q == OP_PUSH) begin
      if (limit_hit) begin
        status = STATUS_FULL;
      end else if (is_dup) begin
        status = STATUS_DUPLICATE;
      end else begin
        ctrl.push = commit;
        count_d   = count_q + CW'(1);
      end
    end else begin
      if (count_q == '0) begin
        status = STATUS_EMPTY;
      end else begin
        ctrl.pop = commit;
        popped   = cell_value[0];
        count_d  = count_q - CW'(1);
      end
    end
  end

  assign count_d_x = XW'(count_d);

  // Sequencer: take a request, then resolve it once the result register is free.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_i.valid) begin
          state_d = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign in_i.ready = (state_q == ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (commit) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Request and result payload registers.
  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      op_q    <= in_i.op;
      value_q <= in_i.value;
    end
    if (commit) begin
      out_status_q <= status;
      out_popped_q <= popped;
      out_empty_q  <= (count_d == '0);
      out_full_q   <= (count_d != '0) && (count_d_x >= max_x);
      out_occ_q    <= count_d_x[7:0];
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.status       = out_status_q;
  assign out_o.popped_value = out_popped_q;
  assign out_o.is_empty     = out_empty_q;
  assign out_o.is_full      = out_full_q;
  assign out_o.occupancy    = out_occ_q;

`ifndef SYNTHESIS
  // The number of valid cells always matches the entry count.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(cell_valid) == 32'(count_q))
    else $error("cell valid bits disagree with entry count");

  // Occupancy never exceeds the built depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH))
    else $error("entry count beyond depth");

  // A completed push grows the queue by exactly one entry.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.push |=> count_q == $past(count_q) + CW'(1))
    else $error("push did not add one entry");

  // A duplicate refusal leaves the chain untouched.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (commit && status == STATUS_DUPLICATE) |=> $stable(cell_valid))
    else $error("duplicate push changed the queue");
`endif

endmodule
